// File: sv/vbm_pkg.sv
// Shared types, constants and codes of the vertical 16-row box mean block.
package vbm_pkg;

    // Storage geometry.
    localparam int MAX_ROW_BYTES = 16384;
    localparam int WINDOW_ROWS   = 16;
    localparam int COL_W         = $clog2(MAX_ROW_BYTES);
    localparam int SLOT_W        = $clog2(WINDOW_ROWS);
    localparam int ROWS_W        = SLOT_W + 1;
    localparam int RING_AW       = SLOT_W + COL_W;
    localparam int RING_DEPTH    = WINDOW_ROWS * MAX_ROW_BYTES;

    // Field and arithmetic widths.
    localparam int BYTE_W    = 8;
    localparam int SUM_W     = 12;
    localparam int CFG_W     = 15;
    localparam int LEN_W     = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam int APB_AW    = 3;
    localparam int APB_DW    = 32;

    // Register reset value.
    localparam logic [CFG_W-1:0] ROW_BYTES_RESET = 15'd14661;

    // Queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // How the back updates a column sum.
    localparam logic [1:0] MODE_FIRST  = 2'd0;
    localparam logic [1:0] MODE_ACCUM  = 2'd1;
    localparam logic [1:0] MODE_WINDOW = 2'd2;

    typedef struct packed {
        logic [BYTE_W-1:0] pixel_byte;
        logic              frame_start;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] mean_byte;
        logic              row_end;
    } out_item_t;

    // One classified byte as handed from the front to the back.
    typedef struct packed {
        logic [BYTE_W-1:0] pixel_byte;
        logic [COL_W-1:0]  col;
        logic [SLOT_W-1:0] slot;
        logic [1:0]        mode;
        logic              produce;
        logic              last;
    } desc_t;

    // Handshake group of the descriptor queue.
    typedef struct packed {
        logic  valid;
        desc_t desc;
    } desc_chan_t;

endpackage

// File: sv/vertical_box_mean_16_rows_core.sv
// Vertical 16-row box mean: takes one byte per clock, row-major, and keeps a
// running 16-row sum for every byte column together with a 16-row ring of the
// bytes themselves. From the sixteenth row of a frame on, each byte yields
// floor(sum / 16), the mean for the row eight above the newest one; earlier
// bytes yield no result. The sustained rate is one transaction per clock. A
// byte's result is offered after these registered steps: the queue entry is
// written at the accepting edge, the memories are read as the descriptor leaves
// the queue, and the update stage loads the sum update into the output register.
// The one-per-clock rate is set by the column-sum memory's read-modify-write,
// which a one-entry forward keeps going at full rate when consecutive bytes hit
// the same column. While a result waits at the output, the update stage and the
// two-entry queue fill and the input then holds off. The memories are not
// cleared after reset and need no clearing pass. The row length register sits
// at byte address 0 of the APB port; zero is taken as one and values above the
// storage size are clamped to it.
module vertical_box_mean_16_rows_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [vbm_pkg::APB_AW-1:0]   paddr,
    input  logic [vbm_pkg::APB_DW-1:0]   pwdata,
    output logic [vbm_pkg::APB_DW-1:0]   prdata,
    output logic                         pready,
    // Input bytes.
    input  logic                         s_valid,
    output logic                         s_ready,
    input  vbm_pkg::in_item_t            s_data,
    // Results.
    output logic                         m_valid,
    input  logic                         m_ready,
    output vbm_pkg::out_item_t           m_data
);

    logic [vbm_pkg::CFG_W-1:0] row_bytes_reg;
    logic                      q_full;
    logic                      pop;
    vbm_pkg::desc_chan_t       push;
    vbm_pkg::desc_chan_t       head;

    // Row length register; only the word at address 0 is decoded.
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_bytes_reg <= vbm_pkg::ROW_BYTES_RESET;
        end else if (psel && penable && pwrite && pready && !paddr[2]) begin
            row_bytes_reg <= pwdata[vbm_pkg::CFG_W-1:0];
        end
    end

    always_comb begin
        if (!paddr[2]) begin
            prdata = vbm_pkg::APB_DW'(row_bytes_reg);
        end else begin
            prdata = '0;
        end
    end

    vbm_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .row_bytes (row_bytes_reg),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .q_full    (q_full),
        .push      (push)
    );

    vbm_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .full    (q_full),
        .head    (head),
        .pop     (pop)
    );

    vbm_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .head    (head),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

// File: sv/vbm_ram.sv
// Generic single-write, single-read RAM with registered read data.
module vbm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Read port; a read of the address being written returns the old data.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/vbm_front.sv
// Front end: accepts input bytes, tracks column, ring slot and row count.
module vbm_front (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [vbm_pkg::CFG_W-1:0]   row_bytes,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  vbm_pkg::in_item_t           s_data,
    input  logic                        q_full,
    output vbm_pkg::desc_chan_t         push
);

    logic [vbm_pkg::COL_W-1:0]  column_index_reg, column_index_next;
    logic [vbm_pkg::ROWS_W-1:0] rows_seen_reg, rows_seen_next;
    logic [vbm_pkg::SLOT_W-1:0] ring_slot_reg, ring_slot_next;

    logic [vbm_pkg::LEN_W-1:0]  len_raw;
    logic [vbm_pkg::LEN_W-1:0]  len_eff;
    logic [vbm_pkg::COL_W-1:0]  col;
    logic [vbm_pkg::ROWS_W-1:0] rows;
    logic [vbm_pkg::SLOT_W-1:0] slot;
    logic                       last;
    logic                       accept;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Clamp the row length into the range the storage supports.
    assign len_raw = vbm_pkg::LEN_W'(row_bytes);
    always_comb begin
        if (len_raw == '0) begin
            len_eff = vbm_pkg::LEN_W'(1);
        end else if (len_raw > vbm_pkg::LEN_W'(vbm_pkg::MAX_ROW_BYTES)) begin
            len_eff = vbm_pkg::LEN_W'(vbm_pkg::MAX_ROW_BYTES);
        end else begin
            len_eff = len_raw;
        end
    end

    // A frame start restarts the counters for the flagged byte itself.
    assign col  = s_data.frame_start ? '0 : column_index_reg;
    assign rows = s_data.frame_start ? '0 : rows_seen_reg;
    assign slot = s_data.frame_start ? '0 : ring_slot_reg;
    assign last = (vbm_pkg::LEN_W'(col) + vbm_pkg::LEN_W'(1)) >= len_eff;

    // Classify the byte for the back end.
    always_comb begin
        push.valid           = accept;
        push.desc.pixel_byte = s_data.pixel_byte;
        push.desc.col        = col;
        push.desc.slot       = slot;
        push.desc.last       = last;
        push.desc.produce    = rows >= vbm_pkg::ROWS_W'(vbm_pkg::WINDOW_ROWS - 1);
        if (rows == '0) begin
            push.desc.mode = vbm_pkg::MODE_FIRST;
        end else if (rows < vbm_pkg::ROWS_W'(vbm_pkg::WINDOW_ROWS)) begin
            push.desc.mode = vbm_pkg::MODE_ACCUM;
        end else begin
            push.desc.mode = vbm_pkg::MODE_WINDOW;
        end
    end

    // Counter update on each accepted transaction.
    always_comb begin
        column_index_next = column_index_reg;
        rows_seen_next    = rows_seen_reg;
        ring_slot_next    = ring_slot_reg;
        if (accept) begin
            if (last) begin
                column_index_next = '0;
                ring_slot_next    = slot + vbm_pkg::SLOT_W'(1);
                if (rows < vbm_pkg::ROWS_W'(vbm_pkg::WINDOW_ROWS)) begin
                    rows_seen_next = rows + vbm_pkg::ROWS_W'(1);
                end else begin
                    rows_seen_next = rows;
                end
            end else begin
                column_index_next = col + vbm_pkg::COL_W'(1);
                rows_seen_next    = rows;
                ring_slot_next    = slot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            column_index_reg <= '0;
            rows_seen_reg    <= '0;
            ring_slot_reg    <= '0;
        end else begin
            column_index_reg <= column_index_next;
            rows_seen_reg    <= rows_seen_next;
            ring_slot_reg    <= ring_slot_next;
        end
    end

endmodule

// File: sv/vbm_queue.sv
// Short descriptor queue between the front end and the back end.
module vbm_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  vbm_pkg::desc_chan_t push,
    output logic                full,
    output vbm_pkg::desc_chan_t head,
    input  logic                pop
);

    vbm_pkg::desc_t              entry_reg [vbm_pkg::QUEUE_DEPTH];
    logic [vbm_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [vbm_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [vbm_pkg::QCNT_W-1:0]  count_reg, count_next;
    logic                        do_push;
    logic                        do_pop;

    assign full    = count_reg == vbm_pkg::QCNT_W'(vbm_pkg::QUEUE_DEPTH);
    assign do_push = push.valid && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = count_reg != '0;
    assign head.desc  = entry_reg[rd_ptr_reg];

    // Pointer and occupancy bookkeeping.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            if (wr_ptr_reg == vbm_pkg::QPTR_W'(vbm_pkg::QUEUE_DEPTH - 1)) begin
                wr_ptr_next = '0;
            end else begin
                wr_ptr_next = wr_ptr_reg + vbm_pkg::QPTR_W'(1);
            end
        end
        if (do_pop) begin
            if (rd_ptr_reg == vbm_pkg::QPTR_W'(vbm_pkg::QUEUE_DEPTH - 1)) begin
                rd_ptr_next = '0;
            end else begin
                rd_ptr_next = rd_ptr_reg + vbm_pkg::QPTR_W'(1);
            end
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + vbm_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - vbm_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push.desc;
        end
    end

endmodule

// File: sv/vbm_back.sv
// Back end: column-sum read-modify-write, row ring update and result register.
module vbm_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  vbm_pkg::desc_chan_t head,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output vbm_pkg::out_item_t  m_data
);

    logic                         b_valid_reg;
    vbm_pkg::desc_t               b_desc_reg;
    logic                         fwd_reg;
    logic [vbm_pkg::SUM_W-1:0]    fwd_sum_reg;
    logic                         m_valid_reg;
    vbm_pkg::out_item_t           m_data_reg;

    logic [vbm_pkg::SUM_W-1:0]    sums_rdata;
    logic [vbm_pkg::BYTE_W-1:0]   ring_rdata;
    logic [vbm_pkg::SUM_W-1:0]    old_sum;
    logic [vbm_pkg::SUM_W-1:0]    byte_ext;
    logic [vbm_pkg::SUM_W-1:0]    b_sum;
    logic                         out_free;
    logic                         b_fire;

    // The stage fires when its result, if any, has room in the output register.
    assign out_free = !m_valid_reg || m_ready;
    assign b_fire   = b_valid_reg && (!b_desc_reg.produce || out_free);
    assign pop      = head.valid && (!b_valid_reg || b_fire);

    // Column sums, read when a descriptor leaves the queue, written on fire.
    vbm_ram #(
        .WIDTH (vbm_pkg::SUM_W),
        .DEPTH (vbm_pkg::MAX_ROW_BYTES)
    ) u_sums (
        .aclk    (aclk),
        .wr_en   (b_fire),
        .wr_addr (b_desc_reg.col),
        .wr_data (b_sum),
        .rd_en   (pop),
        .rd_addr (head.desc.col),
        .rd_data (sums_rdata)
    );

    // Ring of the last sixteen rows, addressed by slot and column.
    vbm_ram #(
        .WIDTH (vbm_pkg::BYTE_W),
        .DEPTH (vbm_pkg::RING_DEPTH)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (b_fire),
        .wr_addr ({b_desc_reg.slot, b_desc_reg.col}),
        .wr_data (b_desc_reg.pixel_byte),
        .rd_en   (pop),
        .rd_addr ({head.desc.slot, head.desc.col}),
        .rd_data (ring_rdata)
    );

    // New column sum; a sum written in the cycle of the read is forwarded.
    assign old_sum  = fwd_reg ? fwd_sum_reg : sums_rdata;
    assign byte_ext = vbm_pkg::SUM_W'(b_desc_reg.pixel_byte);
    always_comb begin
        case (b_desc_reg.mode)
            vbm_pkg::MODE_FIRST:  b_sum = byte_ext;
            vbm_pkg::MODE_ACCUM:  b_sum = old_sum + byte_ext;
            vbm_pkg::MODE_WINDOW: b_sum = old_sum - vbm_pkg::SUM_W'(ring_rdata) + byte_ext;
            default:              b_sum = byte_ext;
        endcase
    end

    // Update stage control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (pop) begin
            b_valid_reg <= 1'b1;
        end else if (b_fire) begin
            b_valid_reg <= 1'b0;
        end
    end

    // Update stage payload and forwarding record.
    always_ff @(posedge aclk) begin
        if (pop) begin
            b_desc_reg  <= head.desc;
            fwd_reg     <= b_fire && (b_desc_reg.col == head.desc.col);
            fwd_sum_reg <= b_sum;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_fire && b_desc_reg.produce) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_fire && b_desc_reg.produce) begin
            m_data_reg.mean_byte <= b_sum[vbm_pkg::SUM_W-1:vbm_pkg::SUM_W-vbm_pkg::BYTE_W];
            m_data_reg.row_end   <= b_desc_reg.last;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
